### sv/rlfl_pkg.sv
package rlfl_pkg;

    localparam int LinkW = 8;
    localparam int PtrW  = 7;
    localparam int CntW  = 7;
    localparam int KeyW  = 4;
    localparam int StW   = 2;

    localparam logic [KeyW-1:0] MaxKeyWidth = 4'd8;

    localparam logic [StW-1:0] ST_OK      = 2'd0;
    localparam logic [StW-1:0] ST_FULL    = 2'd1;
    localparam logic [StW-1:0] ST_RANGE   = 2'd2;
    localparam logic [StW-1:0] ST_BADFREE = 2'd3;

    typedef struct packed {
        logic            req_type;
        logic [KeyW-1:0] key_width;
        logic [PtrW-1:0] slot_ptr;
    } t_req;

    typedef struct packed {
        logic [PtrW-1:0] granted_ptr;
        logic [StW-1:0]  status;
        logic [CntW-1:0] used_count;
    } t_rsp;

    typedef struct packed {
        logic           load;
        logic           rd_head;
        logic           walk_step;
        logic           found;
        logic           pop_done;
        logic           unlink_done;
        logic           do_free;
        logic           fail;
        logic [StW-1:0] fail_code;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic free_ok;
        logic full;
        logic head_ok;
        logic pop_direct;
        logic link_hit;
        logic link_bad;
    } t_sts;

    function automatic logic ptr_ok(logic [LinkW-1:0] p, logic [LinkW-1:0] n);
        return (p != '0) && (p <= n);
    endfunction

endpackage

### sv/rlfl_ram.sv
module rlfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 127
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rlfl_ctrl.sv
module rlfl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rlfl_pkg::t_cmd o_cmd,
    input  rlfl_pkg::t_sts i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_POP    = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_UNLINK = 3'd4;

    logic [2:0]     r_state, n_state;
    logic           r_out_valid, n_out_valid;
    rlfl_pkg::t_cmd cmd;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        cmd         = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_free) begin
                    if (i_sts.free_ok) begin
                        cmd.do_free = 1'b1;
                    end else begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = rlfl_pkg::ST_BADFREE;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_sts.full) begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = rlfl_pkg::ST_FULL;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end else if (!i_sts.head_ok) begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = rlfl_pkg::ST_RANGE;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.rd_head = 1'b1;
                    n_state     = i_sts.pop_direct ? S_POP : S_WALK;
                end
            end
            S_POP: begin
                cmd.pop_done = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            S_WALK: begin
                if (i_sts.link_hit) begin
                    cmd.found = 1'b1;
                    n_state   = S_UNLINK;
                end else if (i_sts.link_bad) begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = rlfl_pkg::ST_RANGE;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_UNLINK: begin
                cmd.unlink_done = 1'b1;
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/rlfl_dp.sv
module rlfl_dp #(
    parameter int BIN_SIZE = 127
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rlfl_pkg::t_req i_req,
    input  rlfl_pkg::t_cmd i_cmd,
    output rlfl_pkg::t_sts o_sts,
    output rlfl_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(BIN_SIZE);
    localparam int LW = rlfl_pkg::LinkW;
    localparam int CW = rlfl_pkg::CntW;
    localparam int PW = rlfl_pkg::PtrW;

    localparam logic [LW-1:0] BinLink = LW'(BIN_SIZE);
    localparam logic [CW-1:0] BinCnt  = CW'(BIN_SIZE);

    logic [LW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [BIN_SIZE-1:0] r_vld;
    logic [AW-1:0]       r_rd_addr;
    logic                r_rd_vld;

    logic                r_is_free;
    logic [PW-1:0]       r_ptr;
    logic                r_nolimit;
    logic [LW-1:0]       r_thr;
    logic [LW-1:0]       r_prev;
    logic [LW-1:0]       r_cur;
    logic [CW-1:0]       r_steps;
    rlfl_pkg::t_rsp      r_rsp;

    logic [LW-1:0] ram_q;
    logic [LW-1:0] rd_link;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [LW-1:0] wdata;
    logic [CW-1:0] free_cnt;
    logic [2:0]    shamt;

    // unwritten entries read back as their reset link
    assign rd_link = r_rd_vld ? ram_q : (LW'(r_rd_addr) + LW'(2));

    assign rd_en   = i_cmd.rd_head | i_cmd.walk_step | i_cmd.found;
    assign rd_addr = i_cmd.rd_head ? AW'(r_head - LW'(1)) : AW'(rd_link - LW'(1));
    assign we      = i_cmd.do_free | i_cmd.unlink_done;
    assign waddr   = i_cmd.do_free ? AW'(r_ptr - PW'(1)) : AW'(r_prev - LW'(1));
    assign wdata   = i_cmd.do_free ? r_head : rd_link;

    assign free_cnt = BinCnt - r_count;

    always_comb begin
        if (i_req.key_width == '0) begin
            shamt = 3'd0;
        end else if (i_req.key_width >= rlfl_pkg::MaxKeyWidth) begin
            shamt = 3'd7;
        end else begin
            shamt = 3'(i_req.key_width - 4'd1);
        end
    end

    always_comb begin
        o_sts.is_free    = r_is_free;
        o_sts.free_ok    = rlfl_pkg::ptr_ok(LW'(r_ptr), BinLink) && (r_count != '0);
        o_sts.full       = r_count >= BinCnt;
        o_sts.head_ok    = rlfl_pkg::ptr_ok(r_head, BinLink);
        o_sts.pop_direct = r_nolimit || (r_head < r_thr);
        o_sts.link_hit   = rlfl_pkg::ptr_ok(rd_link, BinLink) && (rd_link < r_thr);
        o_sts.link_bad   = !rlfl_pkg::ptr_ok(rd_link, BinLink) || (r_steps >= free_cnt);
    end

    rlfl_ram #(
        .WIDTH(LW),
        .DEPTH(BIN_SIZE)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= LW'(1);
            r_count <= '0;
            r_vld   <= '0;
        end else begin
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (i_cmd.pop_done) begin
                r_head <= rd_link;
            end else if (i_cmd.do_free) begin
                r_head <= LW'(r_ptr);
            end
            if (i_cmd.pop_done || i_cmd.unlink_done) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.do_free) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_addr <= rd_addr;
            r_rd_vld  <= r_vld[rd_addr];
        end
        if (i_cmd.load) begin
            r_is_free <= i_req.req_type;
            r_ptr     <= i_req.slot_ptr;
            r_nolimit <= (i_req.key_width >= rlfl_pkg::MaxKeyWidth);
            r_thr     <= LW'(1) << shamt;
        end
        if (i_cmd.rd_head) begin
            r_prev  <= r_head;
            r_steps <= CW'(1);
        end else if (i_cmd.walk_step) begin
            r_prev  <= rd_link;
            r_steps <= r_steps + CW'(1);
        end
        if (i_cmd.found) begin
            r_cur <= rd_link;
        end
        if (i_cmd.pop_done) begin
            r_rsp.granted_ptr <= r_head[PW-1:0];
            r_rsp.status      <= rlfl_pkg::ST_OK;
            r_rsp.used_count  <= r_count + CW'(1);
        end else if (i_cmd.unlink_done) begin
            r_rsp.granted_ptr <= r_cur[PW-1:0];
            r_rsp.status      <= rlfl_pkg::ST_OK;
            r_rsp.used_count  <= r_count + CW'(1);
        end else if (i_cmd.do_free) begin
            r_rsp.granted_ptr <= '0;
            r_rsp.status      <= rlfl_pkg::ST_OK;
            r_rsp.used_count  <= r_count - CW'(1);
        end else if (i_cmd.fail) begin
            r_rsp.granted_ptr <= '0;
            r_rsp.status      <= i_cmd.fail_code;
            r_rsp.used_count  <= r_count;
        end
    end

    assign o_rsp = r_rsp;

endmodule

### sv/range_limited_free_list_allocator_top.sv
// Slot allocator for one bin of BIN_SIZE slots, named by 1-based pointers and kept
// free on a singly linked list in a simple dual-port link RAM with registered read.
// One request is handled at a time and each gives exactly one result beat. A free,
// or any request that fails at once (full bin, bad free pointer, bad head), is settled
// in the decide state; an allocate that pops the head reads the head link and ends in
// the pop state; a range-limited allocate walks the list one link RAM read per cycle,
// bounded by the count of free slots, and then unlinks the slot that it found. The next
// request is taken once the result beat has been taken or is taken in the same cycle.
module range_limited_free_list_allocator_top #(
    parameter int BIN_SIZE = 127
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rlfl_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rlfl_pkg::t_rsp o_out_data
);

    rlfl_pkg::t_cmd cmd;
    rlfl_pkg::t_sts sts;

    rlfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rlfl_dp #(
        .BIN_SIZE(BIN_SIZE)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_in_data),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_rsp  (o_out_data)
    );

endmodule

### test/range_limited_free_list_allocator_top_tb.sv
module range_limited_free_list_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BIN          = 127;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_CAP    = 40;

    localparam int LINK_W = rlfl_pkg::LinkW;
    localparam int PTR_W  = rlfl_pkg::PtrW;
    localparam int CNT_W  = rlfl_pkg::CntW;
    localparam int KEY_W  = rlfl_pkg::KeyW;
    localparam int ST_W   = rlfl_pkg::StW;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct {
        rlfl_pkg::t_req req;
        bit             known;
        rlfl_pkg::t_rsp rsp;
    } t_dir_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    rlfl_pkg::t_req i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    rlfl_pkg::t_rsp o_out_data;

    // predictor state
    logic [LINK_W-1:0] link_mem [1:BIN];
    logic [LINK_W-1:0] head_slot;
    int                slots_used;

    t_dir_row          dir_rows[$];
    rlfl_pkg::t_rsp    rsp_due_q[$];
    logic [PTR_W-1:0]  held_slots_q[$];

    bit             row_known;
    rlfl_pkg::t_rsp row_rsp;
    rlfl_pkg::t_rsp predicted;
    rlfl_pkg::t_rsp oldest;
    int             error_count;
    int             items_in;
    int             idle_cycles;
    int             burst_left;
    bit             held_off;

    range_limited_free_list_allocator_top #(
        .BIN_SIZE(BIN)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit slot_valid(int p);
        return p >= 1 && p <= BIN;
    endfunction

    function automatic rlfl_pkg::t_rsp bin_request_outcome(rlfl_pkg::t_req r);
        rlfl_pkg::t_rsp rsp;
        int   w;
        int   thr;
        int   cur;
        int   prev;
        int   steps;
        int   avail;
        bit   walking;
        rsp = '0;
        rsp.status = rlfl_pkg::ST_OK;
        if (r.req_type == REQ_ALLOC) begin
            w = int'(r.key_width);
            if (w < 1) w = 1;
            if (w > int'(rlfl_pkg::MaxKeyWidth)) w = int'(rlfl_pkg::MaxKeyWidth);
            thr = 1 << (w - 1);
            cur = int'(head_slot);
            walking = 1'b1;
            if (slots_used >= BIN) begin
                rsp.status = rlfl_pkg::ST_FULL;
            end else if (!slot_valid(cur)) begin
                rsp.status = rlfl_pkg::ST_RANGE;
            end else if (w == int'(rlfl_pkg::MaxKeyWidth) || cur < thr) begin
                head_slot = link_mem[cur];
            end else begin
                avail = BIN - slots_used;
                steps = 1;
                prev = cur;
                cur = int'(link_mem[prev]);
                while (walking && !(slot_valid(cur) && cur < thr)) begin
                    if (!slot_valid(cur) || steps >= avail) begin
                        rsp.status = rlfl_pkg::ST_RANGE;
                        walking = 1'b0;
                    end else begin
                        prev = cur;
                        cur = int'(link_mem[prev]);
                        steps++;
                    end
                end
                if (walking) link_mem[prev] = link_mem[cur];
            end
            if (rsp.status == rlfl_pkg::ST_OK) begin
                slots_used++;
                rsp.granted_ptr = PTR_W'(cur);
            end
        end else if (!slot_valid(int'(r.slot_ptr)) || slots_used == 0) begin
            rsp.status = rlfl_pkg::ST_BADFREE;
        end else begin
            link_mem[r.slot_ptr] = head_slot;
            head_slot = LINK_W'(r.slot_ptr);
            slots_used--;
        end
        rsp.used_count = CNT_W'(slots_used);
        return rsp;
    endfunction

    function automatic void add_row(logic kind, int width, int ptr, bit known,
                                    int gptr, logic [ST_W-1:0] st, int cnt);
        t_dir_row row;
        row.req.req_type    = kind;
        row.req.key_width   = KEY_W'(width);
        row.req.slot_ptr    = PTR_W'(ptr);
        row.known           = known;
        row.rsp.granted_ptr = PTR_W'(gptr);
        row.rsp.status      = st;
        row.rsp.used_count  = CNT_W'(cnt);
        dir_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_CAP)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // entered at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_item(input rlfl_pkg::t_req r, input bit known,
                             input rlfl_pkg::t_rsp rsp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        row_known  <= known;
        row_rsp    <= rsp;
        @(posedge i_clk);
        while (!(i_in_valid && o_in_ready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        for (int s = 1; s <= BIN; s++) link_mem[s] = LINK_W'(s + 1);
        head_slot  = 1;
        slots_used = 0;
    end

    // output side: own stall pattern plus one long hold-off
    initial begin : receiver
        int cyc;
        cyc = 0;
        held_off = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && items_in >= HOLD_AT) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            cyc++;
            case ((cyc / 97) % 4)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= (cyc % 5) != 0;
                default: i_out_ready <= $urandom_range(0, 9) > 7;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predicted = bin_request_outcome(i_in_data);
                if (i_in_data.req_type == REQ_ALLOC && predicted.status == rlfl_pkg::ST_OK)
                    held_slots_q.push_back(predicted.granted_ptr);
                rsp_due_q.push_back(row_known ? row_rsp : predicted);
                items_in++;
            end
            if (o_out_valid && i_out_ready) begin
                if (rsp_due_q.size() == 0) begin
                    report_mismatch("result beat with nothing due", 1, 0);
                end else begin
                    oldest = rsp_due_q.pop_front();
                    if (o_out_data.granted_ptr !== oldest.granted_ptr)
                        report_mismatch("granted_ptr", o_out_data.granted_ptr,
                                        oldest.granted_ptr);
                    if (o_out_data.status !== oldest.status)
                        report_mismatch("status", o_out_data.status, oldest.status);
                    if (o_out_data.used_count !== oldest.used_count)
                        report_mismatch("used_count", o_out_data.used_count,
                                        oldest.used_count);
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        rlfl_pkg::t_req r;
        rlfl_pkg::t_rsp none;
        int   idx;
        int   pct;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        row_known   = 1'b0;
        row_rsp     = '0;
        none        = '0;
        error_count = 0;
        items_in    = 0;
        idle_cycles = 0;
        burst_left  = 0;

        // fresh bin: list runs 1..BIN
        add_row(REQ_FREE,  0,   5,   1, 0, rlfl_pkg::ST_BADFREE, 0);
        add_row(REQ_ALLOC, 8,   0,   1, 1, rlfl_pkg::ST_OK,      1);
        add_row(REQ_ALLOC, 1,   0,   1, 0, rlfl_pkg::ST_RANGE,   1);
        add_row(REQ_ALLOC, 0,   127, 1, 0, rlfl_pkg::ST_RANGE,   1);
        add_row(REQ_FREE,  15,  0,   1, 0, rlfl_pkg::ST_BADFREE, 1);
        add_row(REQ_ALLOC, 15,  0,   1, 2, rlfl_pkg::ST_OK,      2);
        add_row(REQ_ALLOC, 3,   0,   1, 3, rlfl_pkg::ST_OK,      3);
        add_row(REQ_ALLOC, 3,   0,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_ALLOC, 2,   0,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_FREE,  0,   2,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_ALLOC, 7,   0,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_ALLOC, 8,   0,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_ALLOC, 8,   0,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_FREE,  0,   1,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_FREE,  0,   4,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_ALLOC, 6,   0,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_ALLOC, 2,   0,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_ALLOC, 4,   85,  0, 0, rlfl_pkg::ST_OK,      0);
        // double free of a slot still on the list
        add_row(REQ_FREE,  0,   127, 0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_ALLOC, 8,   0,   0, 0, rlfl_pkg::ST_OK,      0);
        add_row(REQ_ALLOC, 5,   42,  0, 0, rlfl_pkg::ST_OK,      0);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) send_item(dir_rows[k].req, dir_rows[k].known, dir_rows[k].rsp);

        // fill and drain phases with mostly well-formed frees
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pct = ((n / 200) % 2 == 0) ? 92 : 25;
            if ($urandom_range(0, 99) < pct) begin
                r.req_type = REQ_ALLOC;
                r.slot_ptr = PTR_W'($urandom_range(0, 127));
                case ($urandom_range(0, 9))
                    0:             r.key_width = KEY_W'($urandom_range(0, 15));
                    1, 2, 3, 4:    r.key_width = KEY_W'($urandom_range(1, 7));
                    default:       r.key_width = rlfl_pkg::MaxKeyWidth;
                endcase
            end else begin
                r.req_type  = REQ_FREE;
                r.key_width = KEY_W'($urandom_range(0, 15));
                if (held_slots_q.size() != 0 && $urandom_range(0, 99) < 85) begin
                    idx = $urandom_range(0, held_slots_q.size() - 1);
                    r.slot_ptr = held_slots_q[idx];
                    held_slots_q.delete(idx);
                end else begin
                    r.slot_ptr = PTR_W'($urandom_range(0, 127));
                end
            end
            send_item(r, 1'b0, none);
        end
        i_in_valid <= 1'b0;

        while (rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (BIN + 8) @(posedge i_clk);
        if (rsp_due_q.size() != 0)
            report_mismatch("results still due", rsp_due_q.size(), 0);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/rlfl_pkg.sv
sv/rlfl_ram.sv
sv/rlfl_ctrl.sv
sv/rlfl_dp.sv
sv/range_limited_free_list_allocator_top.sv
test/range_limited_free_list_allocator_top_tb.sv
